// ===== hw/rtl/kwsf_pkg.sv =====
package kwsf_pkg;

   // line length limit used when the top level is not overridden
   localparam int unsigned MAX_LINE_DEFAULT = 4096;

   // history of recent bytes and keyword table geometry
   localparam int unsigned HIST_DEPTH = 9;
   localparam int unsigned KW_COUNT   = 14;
   localparam int unsigned KW_MAX_LEN = 8;
   localparam int unsigned KW_IDX_W   = $clog2(KW_COUNT);

   // delimiter byte codes
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;

   // highlighted span length bounds
   localparam logic [3:0] SPAN_LEN_MIN = 4'd3;
   localparam logic [3:0] SPAN_LEN_MAX = 4'd10;

   // one input item
   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_line;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic [11:0] span_start;
      logic [3:0]  span_length;
      logic        line_done;
   } rsp_item_type;

   // keyword hit from the matcher
   typedef struct packed {
      logic       hit;
      logic [3:0] len;
   } kwsf_hit_type;

   // keyword text, last character in the low byte
   function automatic logic [63:0] kw_text(input logic [KW_IDX_W-1:0] k);
      logic [63:0] t;
      unique case (k)
         4'd0:    t = 64'("if");
         4'd1:    t = 64'("else");
         4'd2:    t = 64'("for");
         4'd3:    t = 64'("while");
         4'd4:    t = 64'("do");
         4'd5:    t = 64'("switch");
         4'd6:    t = 64'("case");
         4'd7:    t = 64'("default");
         4'd8:    t = 64'("break");
         4'd9:    t = 64'("continue");
         4'd10:   t = 64'("struct");
         4'd11:   t = 64'("enum");
         4'd12:   t = 64'("union");
         4'd13:   t = 64'("return");
         default: t = '0;
      endcase
      return t;
   endfunction

   // keyword length in bytes
   function automatic logic [3:0] kw_len(input logic [KW_IDX_W-1:0] k);
      logic [3:0] n;
      unique case (k)
         4'd0:    n = 4'd2;
         4'd1:    n = 4'd4;
         4'd2:    n = 4'd3;
         4'd3:    n = 4'd5;
         4'd4:    n = 4'd2;
         4'd5:    n = 4'd6;
         4'd6:    n = 4'd4;
         4'd7:    n = 4'd7;
         4'd8:    n = 4'd5;
         4'd9:    n = 4'd8;
         4'd10:   n = 4'd6;
         4'd11:   n = 4'd4;
         4'd12:   n = 4'd5;
         4'd13:   n = 4'd6;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== hw/rtl/kwsf_match.sv =====
module kwsf_match (
   input  logic [7:0]               recent [kwsf_pkg::HIST_DEPTH],
   input  logic [3:0]               count,
   output kwsf_pkg::kwsf_hit_type   result
);

   localparam int unsigned KW_COUNT   = kwsf_pkg::KW_COUNT;
   localparam int unsigned KW_MAX_LEN = kwsf_pkg::KW_MAX_LEN;
   localparam int unsigned KW_IDX_W   = kwsf_pkg::KW_IDX_W;

   // parallel compare of every keyword against the history, first in table order wins
   always_comb begin
      logic [63:0] text;
      logic [3:0]  len;
      logic        same;
      result = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         text = kwsf_pkg::kw_text(KW_IDX_W'(k));
         len  = kwsf_pkg::kw_len(KW_IDX_W'(k));
         same = (len <= count);
         for (int j = 0; j < KW_MAX_LEN; j++) begin
            if (4'(j) < len && recent[j] != text[8*j +: 8]) begin
               same = 1'b0;
            end
         end
         if (same && !result.hit) begin
            result.hit = 1'b1;
            // keyword plus delimiter, plus a leading space of this line
            if (count > len && recent[len] == kwsf_pkg::CHAR_SPACE) begin
               result.len = len + 4'd2;
            end else begin
               result.len = len + 4'd1;
            end
         end
      end
   end

endmodule

// ===== hw/rtl/kwsf_line_state.sv =====
module kwsf_line_state #(
   parameter int unsigned MAX_LINE = kwsf_pkg::MAX_LINE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  kwsf_pkg::req_item_type item,
   output logic                   produce,
   output kwsf_pkg::rsp_item_type result
);

   localparam int unsigned HIST_DEPTH = kwsf_pkg::HIST_DEPTH;
   localparam int unsigned POS_W      = $clog2(MAX_LINE + 1);
   localparam int unsigned EXT_W      = POS_W + 12;

   logic [7:0]       recent_ff [HIST_DEPTH];
   logic [7:0]       recent_in [HIST_DEPTH];
   logic [3:0]       count_ff;
   logic [3:0]       count_in;
   logic [POS_W-1:0] position_ff;
   logic [POS_W-1:0] position_in;

   logic                  in_range;
   logic                  delim;
   kwsf_pkg::kwsf_hit_type hit;
   logic [EXT_W-1:0]      start_ext;

   kwsf_match u_match (
      .recent (recent_ff),
      .count  (count_ff),
      .result (hit)
   );

   // bytes past the line limit are dropped
   assign in_range = (position_ff < POS_W'(MAX_LINE));
   assign delim    = (item.ch == kwsf_pkg::CHAR_SPACE) || (item.ch == kwsf_pkg::CHAR_SEMI);
   assign produce  = in_range && delim && hit.hit;

   // span ends at the current byte
   assign start_ext          = EXT_W'(position_ff) - EXT_W'(hit.len) + EXT_W'(1);
   assign result.span_start  = start_ext[11:0];
   assign result.span_length = hit.len;
   assign result.line_done   = item.end_of_line;

   // next line state
   always_comb begin
      recent_in   = recent_ff;
      count_in    = count_ff;
      position_in = position_ff;
      if (step) begin
         if (in_range) begin
            for (int i = HIST_DEPTH - 1; i > 0; i--) begin
               recent_in[i] = recent_ff[i-1];
            end
            recent_in[0] = item.ch;
            if (count_ff < 4'(HIST_DEPTH)) begin
               count_in = count_ff + 4'd1;
            end
            position_in = position_ff + POS_W'(1);
         end
         if (item.end_of_line) begin
            count_in    = '0;
            position_in = '0;
         end
      end
   end

   // history bytes need no reset, the count marks valid entries
   always_ff @(posedge clock) begin
      recent_ff <= recent_in;
      if (reset) begin
         count_ff    <= '0;
         position_ff <= '0;
      end else begin
         count_ff    <= count_in;
         position_ff <= position_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= 4'(HIST_DEPTH))
      else $error("history count above depth");

   a_eol_clears : assert property (@(posedge clock) disable iff (reset)
      step && item.end_of_line |=> count_ff == 4'd0 && position_ff == '0)
      else $error("line state not cleared after end of line");

   a_hit_on_delim : assert property (@(posedge clock) disable iff (reset)
      produce |-> in_range && delim && hit.len >= kwsf_pkg::SPAN_LEN_MIN)
      else $error("result without delimiter or with short span");

   a_count_tracks_pos : assert property (@(posedge clock) disable iff (reset)
      POS_W'(count_ff) <= position_ff || POS_W < 4)
      else $error("history count ahead of position");
`endif

endmodule

// ===== hw/rtl/c_keyword_span_finder_unit.sv =====
// channel | ports                          | item
// --------+--------------------------------+---------------------------------------
// input   | req_valid, req_stall, req_item | one byte of a line, end-of-line flag
// result  | rsp_valid, rsp_stall, rsp_item | span start, span length, line done
//
// one byte is taken every cycle while req_stall is low; the byte is held in the input
// register and its result in the result register, with the keyword compare between them
// against the nine-byte history
// synchronous active-high reset clears the line position, history count and valids
// req_stall rises only while the input register holds a byte whose result cannot
// enter a full, stalled result register; bytes without a result never wait
module c_keyword_span_finder_unit #(
   parameter int unsigned MAX_LINE = kwsf_pkg::MAX_LINE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  kwsf_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output kwsf_pkg::rsp_item_type rsp_item
);

   logic                   req_valid_ff;
   logic                   req_valid_in;
   kwsf_pkg::req_item_type req_item_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   kwsf_pkg::rsp_item_type rsp_item_ff;

   logic                   produce;
   kwsf_pkg::rsp_item_type result;
   logic                   out_free;
   logic                   advance;
   logic                   take_req;

   kwsf_line_state #(
      .MAX_LINE (MAX_LINE)
   ) u_line_state (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (req_item_ff),
      .produce (produce),
      .result  (result)
   );

   // pipeline flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && (!produce || out_free);
   assign req_stall = req_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   assign req_valid_in = take_req || (req_valid_ff && !advance);
   assign rsp_valid_in = (advance && produce) || (rsp_valid_ff && rsp_stall);

   // input register and result register
   always_ff @(posedge clock) begin
      if (take_req) begin
         req_item_ff <= req_item;
      end
      if (advance && produce) begin
         rsp_item_ff <= result;
      end
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_stall_only_blocked : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff && rsp_valid_ff && rsp_stall && produce)
      else $error("input stalled without a blocked result");

   a_span_len_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.span_length >= kwsf_pkg::SPAN_LEN_MIN &&
                    rsp_item.span_length <= kwsf_pkg::SPAN_LEN_MAX)
      else $error("span length out of range");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_item_ff))
      else $error("waiting result overwritten");
`endif

endmodule

// ===== tb/c_keyword_span_finder_unit_tb.sv =====
`timescale 1ns / 1ps

module c_keyword_span_finder_unit_tb;

   localparam int unsigned LINE_LIMIT   = kwsf_pkg::MAX_LINE_DEFAULT;
   localparam int          RANDOM_ITEMS = 1400;
   localparam int          IDLE_LIMIT   = 600;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          DIR_ROWS     = 25;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   kwsf_pkg::req_item_type req_item  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   kwsf_pkg::rsp_item_type rsp_item;

   c_keyword_span_finder_unit #(
      .MAX_LINE(LINE_LIMIT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   always #6 clock = ~clock;

   // keyword list and predictor line state
   string        kw_words [14] = '{"if", "else", "for", "while", "do", "switch", "case",
                                   "default", "break", "continue", "struct", "enum",
                                   "union", "return"};
   logic [7:0]   hist_bytes [9];
   int unsigned  hist_fill;
   int unsigned  line_pos;

   // spans still to come out of the block, oldest first
   kwsf_pkg::rsp_item_type span_q [$];
   int           mismatch_count = 0;
   bit           send_burst = 1'b0;
   logic [7:0]   line_buf [$];

   // directed rows: typed spans where they are obvious, the rest from the predictor
   typedef struct {
      logic [7:0]  ch;
      logic        eol;
      bit          typed;
      logic [11:0] exp_start;
      logic [3:0]  exp_len;
      logic        exp_done;
   } dir_row_type;

   dir_row_type dir_rows [DIR_ROWS] = '{
      // keyword right after reset, then a keyword with a leading space ending the line
      '{"i", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{"f", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{" ", 1'b0, 1'b1, 12'd0, 4'd3, 1'b0},
      '{"d", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{"o", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{";", 1'b1, 1'b1, 12'd2, 4'd4, 1'b1},
      // zero byte before a keyword, all-ones byte, line ending on a space
      '{8'h00, 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{"i", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{"f", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{";", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{" ", 1'b1, 1'b0, 12'd0, 4'd0, 1'b0},
      // space at the end of the previous line must not be counted
      '{"d", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{"o", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{";", 1'b1, 1'b1, 12'd0, 4'd3, 1'b1},
      // longest keyword with leading space fills the whole history
      '{" ", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{"c", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{"o", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{"n", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{"t", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{"i", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{"n", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{"u", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{"e", 1'b0, 1'b0, 12'd0, 4'd0, 1'b0},
      '{";", 1'b1, 1'b1, 12'd0, 4'd10, 1'b1}
   };

   // clear history, count and position
   function automatic void clear_line_state();
      for (int i = 0; i < 9; i++) hist_bytes[i] = 8'h00;
      hist_fill = 0;
      line_pos  = 0;
   endfunction

   // step the line state by one byte; returns 1 when a span is reported
   function automatic bit predict_span(input logic [7:0] ch, input logic eol,
                                       output kwsf_pkg::rsp_item_type span);
      bit          hit;
      bit          same;
      int unsigned kw_len;
      int unsigned span_len;
      hit  = 1'b0;
      span = '0;
      if (line_pos < LINE_LIMIT) begin
         // delimiter closes a keyword found at the end of the history
         if (ch == kwsf_pkg::CHAR_SPACE || ch == kwsf_pkg::CHAR_SEMI) begin
            for (int k = 0; k < 14 && !hit; k++) begin
               kw_len = kw_words[k].len();
               if (kw_len <= hist_fill) begin
                  same = 1'b1;
                  for (int i = 0; i < kw_len; i++) begin
                     if (hist_bytes[kw_len - 1 - i] != 8'(kw_words[k][i])) same = 1'b0;
                  end
                  if (same) begin
                     span_len = kw_len + 1;
                     if (hist_fill > kw_len && kw_len < 9 &&
                         hist_bytes[kw_len] == kwsf_pkg::CHAR_SPACE) begin
                        span_len++;
                     end
                     span.span_start  = 12'(line_pos - (span_len - 1));
                     span.span_length = 4'(span_len);
                     span.line_done   = eol;
                     hit = 1'b1;
                  end
               end
            end
         end
         // shift the byte into the history
         for (int i = 8; i > 0; i--) hist_bytes[i] = hist_bytes[i - 1];
         hist_bytes[0] = ch;
         if (hist_fill < 9) hist_fill++;
         line_pos++;
      end
      if (eol) clear_line_state();
      return hit;
   endfunction

   // sender gap: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (send_burst || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one byte, wait for it to be taken, record its span
   task automatic send_byte(input logic [7:0] ch, input logic eol, input bit typed,
                            input kwsf_pkg::rsp_item_type typed_span, input int gap);
      kwsf_pkg::rsp_item_type pred;
      bit                     hit;
      req_item  <= '{ch: ch, end_of_line: eol};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      hit = predict_span(ch, eol, pred);
      if (typed) span_q.push_back(typed_span);
      else if (hit) span_q.push_back(pred);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // append one token of C-like text to the line buffer
   task automatic add_token();
      int    sel;
      int    k;
      int    n;
      string w;
      sel = $urandom_range(0, 99);
      k   = $urandom_range(0, 13);
      w   = kw_words[k];
      if (sel < 35) begin
         for (int i = 0; i < w.len(); i++) line_buf.push_back(8'(w[i]));
      end else if (sel < 60) begin
         line_buf.push_back(($urandom_range(0, 1) == 0) ? kwsf_pkg::CHAR_SPACE
                                                         : kwsf_pkg::CHAR_SEMI);
      end else if (sel < 75) begin
         line_buf.push_back(8'($urandom_range(97, 122)));
      end else if (sel < 88) begin
         // broken keyword: a prefix only
         n = $urandom_range(1, w.len() - 1);
         for (int i = 0; i < n; i++) line_buf.push_back(8'(w[i]));
      end else begin
         line_buf.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic build_line(input int target, input bit noisy);
      line_buf.delete();
      while (line_buf.size() < target) begin
         if (noisy) begin
            if ($urandom_range(0, 4) == 0) line_buf.push_back(kwsf_pkg::CHAR_SPACE);
            else line_buf.push_back(8'($urandom_range(0, 255)));
         end else begin
            add_token();
         end
      end
   endtask

   task automatic send_line();
      for (int i = 0; i < line_buf.size(); i++) begin
         send_byte(line_buf[i], (i == line_buf.size() - 1), 1'b0, '0, pick_gap());
      end
   endtask

   // stimulus
   initial begin
      int  sent;
      int  target;
      bit  noisy;
      clear_line_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         send_byte(dir_rows[r].ch, dir_rows[r].eol, dir_rows[r].typed,
                   '{span_start: dir_rows[r].exp_start, span_length: dir_rows[r].exp_len,
                     line_done: dir_rows[r].exp_done}, pick_gap());
      end

      // random lines, mostly well-formed code text
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         send_burst = ($urandom_range(0, 3) == 0);
         noisy      = ($urandom_range(0, 99) < 15);
         target     = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70)
                                                  : $urandom_range(1, 25);
         build_line(target, noisy);
         send_line();
         sent += line_buf.size();
      end

      // short closing line with gaps
      send_burst = 1'b0;
      build_line(12, 1'b0);
      send_line();

      // drain
      if (req_valid) req_valid <= 1'b0;
      while (span_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && span_q.size() == 0) begin
         $display("c_keyword_span_finder_unit verification clean");
      end else begin
         $display("c_keyword_span_finder_unit verification failed");
      end
      $finish;
   end

   // result check, receiver stall and watchdog
   int                     stall_left  = 0;
   int                     mode_left   = 0;
   bit                     rsp_quiet   = 1'b0;
   int                     idle_cycles = 0;
   kwsf_pkg::rsp_item_type exp_span;

   always @(posedge clock) begin
      if (!reset) begin
         // compare taken results with the oldest expected span
         if (rsp_valid && !rsp_stall) begin
            if (span_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected span: start %0d length %0d done %0d",
                           rsp_item.span_start, rsp_item.span_length, rsp_item.line_done);
               end
            end else begin
               exp_span = span_q[0];
               span_q.delete(0);
               if (rsp_item.span_start !== exp_span.span_start ||
                   rsp_item.span_length !== exp_span.span_length ||
                   rsp_item.line_done !== exp_span.line_done) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("span mismatch: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                              exp_span.span_start, exp_span.span_length,
                              exp_span.line_done, rsp_item.span_start,
                              rsp_item.span_length, rsp_item.line_done);
                  end
               end
            end
         end

         // watchdog on cycles with no item moving
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("c_keyword_span_finder_unit verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end

      // receiver stall: quiet stretches, short stalls, a few long ones
      if (mode_left == 0) begin
         rsp_quiet = ($urandom_range(0, 3) == 0);
         mode_left = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!rsp_quiet && $urandom_range(0, 99) < 30) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

endmodule
